@@ sv/mtfe_pkg.sv @@
// ----------------------------------------------------------------------------
// mtfe_pkg
// Shared constants and types for the move-to-front encoder.
// ----------------------------------------------------------------------------
package mtfe_pkg;

  localparam int ALPHABET_SIZE = 256;
  localparam int SYM_W         = 8;
  localparam int IDX_W         = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  // transaction travelling down the cell chain
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    logic             block_start;
    logic [SYM_W-1:0] carry;
    logic             found;
    logic [IDX_W-1:0] rank;
  } mtfe_wave_t;

endpackage

@@ sv/mtfe_cell.sv @@
// ----------------------------------------------------------------------------
// mtfe_cell
// One list position: holds one entry, compares it with the passing symbol
// and swaps it with the carried entry until the symbol has been found.
// ----------------------------------------------------------------------------
module mtfe_cell
  import mtfe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [IDX_W-1:0] cell_idx,
  input  mtfe_wave_t       wave_in,
  output mtfe_wave_t       wave_out
);

  logic [SYM_W-1:0] entry_r;
  logic [SYM_W-1:0] entry_nxt;
  logic [SYM_W-1:0] cur;
  mtfe_wave_t       wave_r;
  mtfe_wave_t       wave_nxt;

  always_comb begin
    cur       = wave_in.block_start ? SYM_W'(cell_idx) : entry_r;
    wave_nxt  = wave_in;
    entry_nxt = entry_r;
    if (wave_in.valid) begin
      if (wave_in.found) begin
        entry_nxt = cur;
      end else if (cur == wave_in.symbol) begin
        entry_nxt      = wave_in.carry;
        wave_nxt.found = 1'b1;
        wave_nxt.rank  = cell_idx;
      end else begin
        entry_nxt      = wave_in.carry;
        wave_nxt.carry = cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r      <= SYM_W'(cell_idx);
      wave_r.valid <= 1'b0;
    end else if (advance) begin
      entry_r <= entry_nxt;
      wave_r  <= wave_nxt;
    end
  end

  assign wave_out = wave_r;

endmodule

@@ sv/move_to_front_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// move_to_front_encoder_unit
// Move-to-front byte encoder built as a systolic chain of list cells.
// ----------------------------------------------------------------------------
// The symbol list lives in a row of ALPHABET_SIZE cells (256), one entry per
// cell. Each transaction walks down the row one cell per cycle unless the row
// is frozen, swapping the carried entry into each cell until it meets its
// symbol, so a new byte can enter every cycle that the row is not frozen and
// the list order stays exact for back-to-back bytes. A rank appears once its
// byte has passed the first cell's register, each further cell register in
// turn and then the output register. When the output register holds an
// untaken rank and out_stall is high, the whole row freezes and in_stall
// rises. block_start restores the identity order as its transaction passes
// each cell, so it needs no idle time. After reset the list is in identity
// order at once.
module move_to_front_encoder_unit
  import mtfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_symbol,
  input  logic       in_block_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_rank
);

  logic             advance;
  logic             out_valid_r;
  logic [IDX_W-1:0] out_rank_r;
  mtfe_wave_t       head;
  mtfe_wave_t       chain [ALPHABET_SIZE];

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  always_comb begin
    head             = '0;
    head.valid       = in_valid;
    head.symbol      = SYM_W'(in_symbol);
    head.block_start = in_block_start;
    head.carry       = SYM_W'(in_symbol);
  end

  for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
    mtfe_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .cell_idx (IDX_W'(k)),
      .wave_in  ((k == 0) ? head : chain[(k == 0) ? 0 : k - 1]),
      .wave_out (chain[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= chain[ALPHABET_SIZE-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rank_r <= chain[ALPHABET_SIZE-1].found ? chain[ALPHABET_SIZE-1].rank
                                                 : IDX_W'(ALPHABET_SIZE - 1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_rank  = 8'(out_rank_r);

endmodule

@@ sv/mtfe_checker.sv @@
// ----------------------------------------------------------------------------
// mtfe_checker
// Port-level checks for the move-to-front encoder, bound to the top level.
// ----------------------------------------------------------------------------
module mtfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_rank
);

  // stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_rank))
    else $error("stalled rank changed");

  // input only stalls behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_no_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind move_to_front_encoder_unit mtfe_checker u_mtfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rank  (out_rank)
);

@@ tb/sv/mtf_rank_checker.sv @@
// ----------------------------------------------------------------------------
// mtf_rank_checker
// Watches both channels of the move-to-front encoder and checks its ranks.
// ----------------------------------------------------------------------------
// Keeps its own copy of the symbol list. Every accepted input transaction is
// coded against that list and the rank is queued. Every accepted output
// transaction is compared with the oldest queued rank. A result with nothing
// queued is a failure too. The number of failures and the number of ranks
// still owed by the block are handed back to the top.
module mtf_rank_checker
  import mtfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_symbol,
  input  logic       in_block_start,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_rank,
  output int         mismatches,
  output int         ranks_due
);

  logic [SYM_W-1:0] symbol_order [ALPHABET_SIZE];
  logic [7:0]       expected_ranks [$];
  int               fail_count;

  function automatic void load_identity();
    for (int k = 0; k < ALPHABET_SIZE; k++) symbol_order[k] = k[SYM_W-1:0];
  endfunction

  // rank of sym in the current order, then sym moves to the front
  function automatic logic [7:0] code_symbol(input logic [7:0] sym, input logic restart);
    int  pos;
    bit  hit;
    pos = 0;
    hit = 1'b0;
    if (restart) load_identity();
    for (int k = 0; k < ALPHABET_SIZE; k++) begin
      if (!hit && symbol_order[k] == sym) begin
        pos = k;
        hit = 1'b1;
      end
    end
    if (!hit) return 8'(ALPHABET_SIZE - 1);
    for (int k = pos; k > 0; k--) symbol_order[k] = symbol_order[k-1];
    symbol_order[0] = sym;
    return pos[7:0];
  endfunction

  initial begin
    fail_count = 0;
    load_identity();
  end

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      load_identity();
      expected_ranks.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_ranks.size() == 0) begin
          if (fail_count < 10) $display("unexpected rank transaction: got %0d", out_rank);
          fail_count++;
        end else begin
          want = expected_ranks.pop_front();
          if (out_rank !== want) begin
            if (fail_count < 10) $display("rank mismatch: expected %0d, got %0d", want, out_rank);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_ranks = {expected_ranks, code_symbol(in_symbol, in_block_start)};
      end
    end
    mismatches <= fail_count;
    ranks_due  <= expected_ranks.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the move-to-front encoder.
// ----------------------------------------------------------------------------
// A short directed run covers the list ends, repeats and block starts, then
// about a thousand random bytes follow, grouped into blocks that mostly open
// with a block start and draw on a small set of hot symbols. The run passes
// through phases of sender gaps and receiver stalls; between phases the
// sender waits until every rank has come back. Checking is done by
// mtf_rank_checker.
module testbench;
  import mtfe_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 300;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_symbol;
  logic       in_block_start;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_rank;
  int         mismatches;
  int         ranks_due;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         quiet_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  move_to_front_encoder_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_symbol      (in_symbol),
    .in_block_start (in_block_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rank       (out_rank)
  );

  mtf_rank_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_symbol      (in_symbol),
    .in_block_start (in_block_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rank       (out_rank),
    .mismatches     (mismatches),
    .ranks_due      (ranks_due)
  );

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  task automatic send_symbol(input logic [7:0] sym, input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_symbol      <= sym;
    in_block_start <= restart;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (ranks_due != 0);
  endtask

  task automatic run_random(input int n_items);
    int         sent;
    int         blk_len;
    logic [7:0] hot [8];
    logic [7:0] sym;
    logic       restart;
    sent = 0;
    while (sent < n_items) begin
      blk_len = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 48);
      for (int k = 0; k < 8; k++) hot[k] = 8'($urandom);
      for (int k = 0; k < blk_len && sent < n_items; k++) begin
        if (k == 0) restart = ($urandom_range(9) != 0);
        else restart = ($urandom_range(49) == 0);
        if ($urandom_range(9) < 6) sym = hot[$urandom_range(7)];
        else sym = 8'($urandom);
        send_symbol(sym, restart);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_symbol      = 8'd0;
    in_block_start = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // list ends, repeats and block starts
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd255, 1'b0);
    send_symbol(8'd255, 1'b0);
    send_symbol(8'd0, 1'b0);
    send_symbol(8'h80, 1'b0);
    send_symbol(8'h80, 1'b0);
    send_symbol(8'h55, 1'b1);
    send_symbol(8'hAA, 1'b0);
    send_symbol(8'h55, 1'b0);
    send_symbol(8'd255, 1'b1);
    send_symbol(8'd0, 1'b1);
    send_symbol(8'd0, 1'b1);
    send_symbol(8'd1, 1'b0);
    send_symbol(8'd1, 1'b0);
    send_symbol(8'd254, 1'b0);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 77;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 77;
        end
        default: begin
          send_idle_pct  = 18;
          recv_stall_pct = 18;
        end
      endcase
      run_random(250);
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && ranks_due == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
